// ===== src/sha256_hash_macros.svh =====
// Assertion macros used by the SHA-256 compression engine
`ifndef SHA256_HASH_MACROS_SVH
`define SHA256_HASH_MACROS_SVH
// assert that a implies b in the same cycle
`define SHA_ASSERT_IMP(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// assert that a implies b in the following cycle
`define SHA_ASSERT_NXT(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

// ===== src/sha_pkg.sv =====
// Types, constants and functions for the SHA-256 hash block
package sha_pkg;

    // one word handed from the front end to the compression engine
    typedef struct packed {
        logic [31:0] word;
        logic        last;   // last word of the message (the low length word)
    } t_word;

    localparam logic [31:0] PadMarker = 32'h8000_0000;

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_const(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

// ===== src/sha256_hash.sv =====
// Top level of the SHA-256 hash block
// Takes a message as big-endian 32-bit words (tlast marks the final word, tuser
// its valid byte count), pads it and returns the eight digest words. The engine
// loads the 16 words of each 512-bit block, then runs 64 rounds and a fold
// step, taking no new words meanwhile; the front end pads into a two-word queue
// while the engine runs. Digest words leave one per cycle while m_axis_tready is high.
module sha256_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // message_word
    input  logic [2:0]  s_axis_tuser,   // valid_bytes
    input  logic        s_axis_tlast,   // final_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic [2:0]  m_axis_tuser,   // word_index
    output logic        m_axis_tlast    // last_of_digest
);
    logic           f_valid, f_ready, c_valid, c_ready;
    sha_pkg::t_word f_data, c_data;

    sha_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_word(s_axis_tdata), .i_nbytes(s_axis_tuser), .i_final(s_axis_tlast),
        .o_valid(f_valid), .i_ready(f_ready), .o_data(f_data)
    );

    sha_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_data(f_data),
        .o_valid(c_valid), .i_ready(c_ready), .o_data(c_data)
    );

    sha_core u_core (
        .i_clk, .i_rst_n,
        .i_valid(c_valid), .o_ready(c_ready), .i_data(c_data),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_word(m_axis_tdata), .o_index(m_axis_tuser), .o_last(m_axis_tlast)
    );
endmodule

// ===== src/sha_front.sv =====
// Front end: takes message words, counts length and generates the padding
module sha_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [31:0]     i_word,
    input  logic [2:0]      i_nbytes,
    input  logic            i_final,
    output logic            o_valid,
    input  logic            i_ready,
    output sha_pkg::t_word  o_data
);
    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StMark = 3'd1;   // marker word after a full final word
    localparam logic [2:0] StZero = 3'd2;
    localparam logic [2:0] StLenH = 3'd3;
    localparam logic [2:0] StLenL = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [3:0]  r_fill, n_fill;
    logic [63:0] r_bits, n_bits;
    logic [2:0]  nb;
    logic [31:0] keep, mark;
    logic        acc;

    assign nb = (i_nbytes > 3'd4) ? 3'd4 : i_nbytes;
    assign acc = o_valid && i_ready;

    // final-word masking and marker placement
    always_comb begin
        unique case (nb)
            3'd0: begin keep = 32'h0000_0000; mark = 32'h8000_0000; end
            3'd1: begin keep = 32'hff00_0000; mark = 32'h0080_0000; end
            3'd2: begin keep = 32'hffff_0000; mark = 32'h0000_8000; end
            3'd3: begin keep = 32'hffff_ff00; mark = 32'h0000_0080; end
            default: begin keep = 32'hffff_ffff; mark = 32'h0000_0000; end
        endcase
    end

    // word selection per state
    always_comb begin
        o_ready = 1'b0;
        o_valid = 1'b0;
        o_data  = '0;
        unique case (r_state)
            StIdle: begin
                o_valid = i_valid;
                o_ready = i_ready;
                o_data.word = i_final ? ((i_word & keep) | mark) : i_word;
            end
            StMark: begin
                o_valid = 1'b1;
                o_data.word = sha_pkg::PadMarker;
            end
            StZero: o_valid = 1'b1;
            StLenH: begin
                o_valid = 1'b1;
                o_data.word = r_bits[63:32];
            end
            StLenL: begin
                o_valid = 1'b1;
                o_data.word = r_bits[31:0];
                o_data.last = 1'b1;
            end
            default: ;
        endcase
    end

    // padding sequencer; next state follows the fill after this word
    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_bits  = r_bits;
        if (acc) begin
            n_fill = r_fill + 4'd1;
            unique case (r_state)
                StIdle: begin
                    if (!i_final) begin
                        n_bits = r_bits + 64'd32;
                    end else begin
                        n_bits = r_bits + {58'd0, nb, 3'd0};
                        if (nb == 3'd4) n_state = StMark;
                        else n_state = (n_fill == 4'd14) ? StLenH : StZero;
                    end
                end
                StMark, StZero: n_state = (n_fill == 4'd14) ? StLenH : StZero;
                StLenH: n_state = StLenL;
                StLenL: begin
                    n_state = StIdle;
                    n_fill  = 4'd0;
                    n_bits  = 64'd0;
                end
                default: n_state = StIdle;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_fill  <= 4'd0;
            r_bits  <= 64'd0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_bits  <= n_bits;
        end
    end
endmodule

// ===== src/sha_fifo.sv =====
// Two-entry word queue between the front end and the engine
module sha_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  sha_pkg::t_word  i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output sha_pkg::t_word  o_data
);
    sha_pkg::t_word r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule

// ===== src/sha_core.sv =====
// Compression engine: block buffer, 64 rounds, chaining value and digest output
module sha_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  sha_pkg::t_word  i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [31:0]     o_word,
    output logic [2:0]      o_index,
    output logic            o_last
);
    `include "sha256_hash_macros.svh"

    localparam logic [1:0] StLoad  = 2'd0;
    localparam logic [1:0] StRound = 2'd1;
    localparam logic [1:0] StFold  = 2'd2;
    localparam logic [1:0] StOut   = 2'd3;

    logic [1:0]  r_state;
    logic [3:0]  r_fill;
    logic [5:0]  r_rnd;
    logic [2:0]  r_idx;
    logic        r_end;      // block being compressed closes the message
    logic [31:0] r_w [16];   // sliding schedule window, w[0] is current
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] s0, s1, wt, t1, t2, e1, e0, ch, mj;
    logic        acc;

    assign o_ready = (r_state == StLoad);
    assign acc = i_valid && o_ready;
    assign o_valid = (r_state == StOut);
    assign o_word  = r_h[0];
    assign o_index = r_idx;
    assign o_last  = (r_idx == 3'd7);

    // one round of schedule and compression
    always_comb begin
        s0 = {r_w[1][6:0], r_w[1][31:7]} ^ {r_w[1][17:0], r_w[1][31:18]} ^ (r_w[1] >> 3);
        s1 = {r_w[14][16:0], r_w[14][31:17]} ^ {r_w[14][18:0], r_w[14][31:19]}
           ^ (r_w[14] >> 10);
        wt = r_w[0] + s0 + r_w[9] + s1;
        e1 = {r_v[4][5:0], r_v[4][31:6]} ^ {r_v[4][10:0], r_v[4][31:11]}
           ^ {r_v[4][24:0], r_v[4][31:25]};
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        e0 = {r_v[0][1:0], r_v[0][31:2]} ^ {r_v[0][12:0], r_v[0][31:13]}
           ^ {r_v[0][21:0], r_v[0][31:22]};
        mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1 = r_v[7] + e1 + ch + sha_pkg::round_const(r_rnd) + r_w[0];
        t2 = e0 + mj;
    end

    always_ff @(posedge i_clk) begin
        // window: load shifts in at the top, rounds shift with new schedule word
        if (acc) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= i_data.word;
        end else if (r_state == StRound) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= wt;
        end
        if (r_state == StRound) begin
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end else if (acc && r_fill == 4'd15) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StLoad;
            r_fill  <= 4'd0;
            r_rnd   <= 6'd0;
            r_idx   <= 3'd0;
            r_end   <= 1'b0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::init_hash(3'(i));
        end else begin
            unique case (r_state)
                StLoad: if (acc) begin
                    r_fill <= r_fill + 4'd1;
                    if (r_fill == 4'd15) begin
                        r_state <= StRound;
                        r_end   <= i_data.last;
                        r_rnd   <= 6'd0;
                    end
                end
                StRound: begin
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_state <= StFold;
                end
                StFold: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_state <= r_end ? StOut : StLoad;
                    r_idx   <= 3'd0;
                end
                StOut: if (i_ready) begin
                    // rotate digest out; after eight words it is the init value
                    for (int i = 0; i < 7; i++) r_h[i] <= r_h[i+1];
                    r_h[7] <= sha_pkg::init_hash(r_idx);
                    r_idx  <= r_idx + 3'd1;
                    if (r_idx == 3'd7) r_state <= StLoad;
                end
                default: r_state <= StLoad;
            endcase
        end
    end

    `SHA_ASSERT_IMP(a_out_only_in_out, i_clk, i_rst_n, o_valid, r_state == StOut, "bad out")
    `SHA_ASSERT_NXT(a_rounds_go, i_clk, i_rst_n, r_state == StRound && r_rnd != 6'd63, r_state == StRound, "round break")
    `SHA_ASSERT_NXT(a_load_to_round, i_clk, i_rst_n, acc && r_fill == 4'd15, r_state == StRound && r_rnd == 6'd0, "no start")
endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the SHA-256 hash block
`timescale 1ns / 100ps

// Digest predictor and queue of expected digest words
class sha_scoreboard;
    logic [31:0] chain[8];
    logic [31:0] blk[16];
    int          fill;
    logic [63:0] bit_len;
    logic [31:0] digest_q[$];
    int          err_cnt;

    function new();
        err_cnt = 0;
        rearm();
    endfunction

    function void rearm();
        for (int i = 0; i < 8; i++) chain[i] = sha_pkg::init_hash(i[2:0]);
        fill    = 0;
        bit_len = '0;
    endfunction

    function logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // 64-round compression of the gathered block
    function void compress();
        logic [31:0] w[16];
        logic [31:0] v[8];
        logic [31:0] wt, t1, t2, x15, x2;
        for (int i = 0; i < 16; i++) w[i] = blk[i];
        for (int i = 0; i < 8; i++) v[i] = chain[i];
        for (int t = 0; t < 64; t++) begin
            if (t < 16) begin
                wt = w[t];
            end else begin
                x15 = w[(t - 15) & 15];
                x2  = w[(t - 2) & 15];
                wt  = w[t & 15] + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3))
                    + w[(t - 7) & 15] + (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10));
                w[t & 15] = wt;
            end
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::round_const(t[5:0]) + wt;
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain[i] += v[i];
    endfunction

    function void add_word(logic [31:0] word);
        blk[fill] = word;
        fill++;
        if (fill == 16) begin
            fill = 0;
            compress();
        end
    endfunction

    // note one accepted input transaction
    function void note_input(logic [31:0] word, logic [2:0] nbytes, logic fin);
        int          n;
        logic [31:0] keep;
        if (!fin) begin
            add_word(word);
            bit_len += 32;
            return;
        end
        n = (nbytes > 4) ? 4 : int'(nbytes);
        bit_len += 8 * n;
        if (n == 4) begin
            add_word(word);
            add_word(sha_pkg::PadMarker);
        end else begin
            keep = (n == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * n));
            add_word((word & keep) | (32'h80 << (24 - 8 * n)));
        end
        while (fill != 14) add_word(32'h0);
        add_word(bit_len[63:32]);
        add_word(bit_len[31:0]);
        for (int i = 0; i < 8; i++) digest_q.push_back(chain[i]);
        rearm();
    endfunction

    // check one accepted output transaction
    function void check_digest(logic [31:0] data, logic [2:0] idx, logic last);
        logic [31:0] exp_word;
        logic [2:0]  exp_idx;
        if (digest_q.size() == 0) begin
            $error("unexpected digest word %h", data);
            err_cnt++;
            return;
        end
        exp_idx  = 3'(7 - ((digest_q.size() - 1) % 8));
        exp_word = digest_q.pop_front();
        if (data !== exp_word) begin
            $error("digest_word expected %h actual %h", exp_word, data);
            err_cnt++;
        end
        if (idx !== exp_idx) begin
            $error("word_index expected %0d actual %0d", exp_idx, idx);
            err_cnt++;
        end
        if (last !== (exp_idx == 3'd7)) begin
            $error("last_of_digest expected %0d actual %0d", exp_idx == 3'd7, last);
            err_cnt++;
        end
    endfunction
endclass

module tb_top;
    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // message_word
    logic [2:0]  s_axis_tuser;   // valid_bytes
    logic        s_axis_tlast;   // final_word
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // digest_word
    logic [2:0]  m_axis_tuser;   // word_index
    logic        m_axis_tlast;   // last_of_digest

    sha_scoreboard digest_sb;
    bit            src_done;
    int            hold_cycles;

    sha256_hash DUT (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // send one word, with a random gap before it
    task automatic send_word(logic [31:0] word, logic [2:0] nbytes, logic fin);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= nbytes;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        digest_sb.note_input(word, nbytes, fin);
    endtask

    // one message of random content; len words before the final one
    task automatic send_message(int len, logic [2:0] last_bytes);
        for (int i = 0; i < len; i++)
            send_word($urandom(), 3'($urandom_range(0, 7)), 1'b0);
        send_word($urandom(), last_bytes, 1'b1);
    endtask

    // stimulus
    initial begin
        int sent;
        int len;
        digest_sb     = new();
        src_done      = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: empty message, each final byte count, field extremes
        for (int b = 0; b < 8; b++) send_word(32'hffff_ffff, 3'(b), 1'b1);
        send_word(32'h0, 3'd4, 1'b1);
        send_word(32'h6162_6300, 3'd3, 1'b1);
        // padding overflow cases around fill 13..15
        send_message(13, 3'd2);
        send_message(14, 3'd0);
        send_message(15, 3'd4);
        // random messages, mostly short, a few long
        sent = 0;
        while (sent < 400) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70)
                                              : $urandom_range(0, 20);
            send_message(len, 3'($urandom_range(0, 7)));
            sent += len + 1;
        end
        s_axis_tvalid <= 1'b0;
        src_done <= 1'b1;
    end

    // receiver: random gap per word, one long hold-off once a digest is pending
    initial begin
        bit held;
        int gap;
        held          = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!held && digest_sb.digest_q.size() >= 8) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                hold_cycles = 0;
                while (hold_cycles < 600) begin
                    @(posedge i_clk);
                    hold_cycles++;
                end
            end
            gap = $urandom_range(0, 3);
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            digest_sb.check_digest(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    // end of run
    initial begin
        wait (src_done);
        while (digest_sb.digest_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (digest_sb.err_cnt == 0 && digest_sb.digest_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog
    initial begin
        #(20 * 400000);
        $display("== FAIL ==");
        $finish;
    end
endmodule
